>>> hw/rtl/lawd_pkg.sv
package lawd_pkg;

   localparam int NSLOT = 4;
   localparam int SRV_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SERVER3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_THR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_THR = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RETAIN_LIM = 3'd6;

   localparam logic [15:0] LOW_THR_RST = 16'd26214;
   localparam logic [15:0] HIGH_THR_RST = 16'd45875;
   localparam logic [15:0] RETAIN_LIM_RST = 16'd32768;

   localparam logic CMD_DISPATCH = 1'b0;
   localparam logic CMD_TICK = 1'b1;
   localparam logic KIND_DISPATCH = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [1:0] BAND_LOW = 2'd0;
   localparam logic [1:0] BAND_MED = 2'd1;
   localparam logic [1:0] BAND_HIGH = 2'd2;

   // slope upper limit, signed Q.14
   localparam logic signed [18:0] SLOPE_MAX = 19'sd245760;

   // divider geometry
   localparam int DIV_W = 21;
   localparam int DIV_LO_W = 18;
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic        command;
      logic [15:0] request_tag;
      logic [15:0] request_load;
      logic [15:0] transfer_cost;
      logic [15:0] preparation_cost;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [15:0]        echo_tag;
      logic               placed;
      logic [1:0]         chosen_server;
      logic signed [39:0] best_cost;
      logic [15:0]        slot_load;
      logic [3:0]         retain_mask;
   } rsp_type;

   typedef struct packed {
      logic                  write_en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_W-1:0]      hi;
      logic [DIV_LO_W-1:0]   lo;
      logic [DIV_CNT_W-1:0]  steps;
      logic [DIV_W-1:0]      den;
   } div_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T_SUM,
      ST_T_LOAD,
      ST_T_LOADW,
      ST_T_SLOPE,
      ST_T_SLOPEW,
      ST_T_RAW,
      ST_T_WGT,
      ST_T_WGTW,
      ST_T_FIN,
      ST_D_PREP1,
      ST_D_PREP2,
      ST_D_MUL1,
      ST_D_MUL2,
      ST_D_ACC,
      ST_D_FIN
   } eng_state_type;

   function automatic logic signed [21:0] weight_base(input logic [1:0] band,
                                                       input logic [1:0] idx);
      logic signed [21:0] b;
      b = 22'sd2;
      unique case (idx)
         2'd0: b = (band == BAND_LOW) ? 22'sd10 : (band == BAND_MED) ? 22'sd8 : 22'sd6;
         2'd1: b = (band == BAND_LOW) ? 22'sd4 : (band == BAND_MED) ? 22'sd6 : 22'sd8;
         2'd2: b = 22'sd4;
         default: b = 22'sd2;
      endcase
      return b;
   endfunction

   function automatic logic signed [21:0] weight_k(input logic [1:0] band,
                                                    input logic [1:0] idx);
      logic signed [21:0] k;
      k = 22'sd0;
      if (band != BAND_LOW) begin
         unique case (idx)
            2'd0: k = 22'sd2;
            2'd1: k = (band == BAND_MED) ? 22'sd1 : 22'sd2;
            default: k = -22'sd1;
         endcase
      end
      return k;
   endfunction

endpackage

>>> hw/rtl/lawd_fifo.sv
module lawd_fifo
   import lawd_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

>>> hw/rtl/lawd_div.sv
module lawd_div
   import lawd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  div_cmd_type          cmd,
   output logic                 done,
   output logic [DIV_LO_W-1:0]  quotient,
   output logic [DIV_W-1:0]     remainder
);
   // restoring divider, one quotient bit per cycle
   logic                 busy_ff, done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     rem_ff, rem_in, den_ff;
   logic [DIV_LO_W-1:0]  lo_ff, quo_ff;
   logic [DIV_W:0]       trial;
   logic                 ge;

   assign trial = {rem_ff, lo_ff[DIV_LO_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});
   always_comb begin
      if (ge) begin
         rem_in = DIV_W'(trial - {1'b0, den_ff});
      end else begin
         rem_in = trial[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_CNT_W'(1));
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= cmd.hi;
         lo_ff  <= cmd.lo;
         den_ff <= cmd.den;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         lo_ff  <= {lo_ff[DIV_LO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[DIV_LO_W-2:0], ge};
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

>>> hw/rtl/lawd_engine.sv
module lawd_engine
   import lawd_pkg::*;
#(
   parameter int NUM_SERVERS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    in_empty,
   input  req_type in_data,
   output logic    in_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_data
);
   eng_state_type state_ff, state_in;

   // configuration
   logic [47:0] srv_ff [NSLOT];
   logic [15:0] low_ff, high_ff, retain_ff;

   // architectural state
   logic [16:0]        used_ff [NSLOT];
   logic [15:0]        prev_ff;
   logic signed [15:0] wgt_ff [NSLOT];

   // work registers
   req_type            cur_ff;
   logic [17:0]        cap_sum_ff, cap_sum_in;
   logic [18:0]        used_sum_ff, used_sum_in;
   logic [15:0]        load_ff;
   logic               neg_ff;
   logic signed [18:0] slope_ff;
   logic signed [21:0] raw_ff [NSLOT];
   logic signed [21:0] sum_ff;
   logic [1:0]         widx_ff;
   logic signed [31:0] a_ff;
   logic signed [33:0] common_ff;
   logic [SRV_W-1:0]   srv_idx_ff;
   logic [31:0]        p_ff;
   logic signed [34:0] r_ff;
   logic signed [48:0] prod_ff;
   logic signed [49:0] best_ff;
   logic [SRV_W-1:0]   best_idx_ff;
   logic               best_ok_ff;

   div_cmd_type           div_cmd;
   logic                  div_done;
   logic [DIV_LO_W-1:0]   div_quo;
   logic [DIV_W-1:0]      div_rem;

   lawd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // ---- tick helpers ----
   always_comb begin
      cap_sum_in  = '0;
      used_sum_in = '0;
      for (int i = 0; i < NSLOT; i++) begin
         if (i < NUM_SERVERS) begin
            cap_sum_in  = cap_sum_in + 18'(srv_ff[i][15:0]);
            used_sum_in = used_sum_in + 19'(used_ff[i]);
         end
      end
   end

   logic signed [16:0] diff;
   logic               diff_neg, slope_sat;
   logic [15:0]        diff_mag;
   logic [19:0]        prev_x15;
   assign diff     = $signed({1'b0, load_ff}) - $signed({1'b0, prev_ff});
   assign diff_neg = diff[16];
   assign diff_mag = diff_neg ? 16'(-diff) : diff[15:0];
   assign prev_x15 = {prev_ff, 4'b0} - {4'b0, prev_ff};
   assign slope_sat = !diff_neg && ({4'b0, diff_mag} >= prev_x15);

   logic [1:0] band;
   always_comb begin
      priority if (load_ff <= low_ff) begin
         band = BAND_LOW;
      end else if (load_ff <= high_ff) begin
         band = BAND_MED;
      end else begin
         band = BAND_HIGH;
      end
   end

   logic signed [21:0] raw_in [NSLOT];
   logic signed [21:0] sum_in;
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NSLOT; i++) begin
         raw_in[i] = (weight_base(band, 2'(i)) <<< 14)
                     + weight_k(band, 2'(i)) * 22'(slope_ff);
         sum_in = sum_in + raw_in[i];
      end
   end

   // weight numerator 2*raw*2^14 + S over 2*S
   logic signed [37:0] wnum;
   logic               wneg, wsat;
   logic [36:0]        wmag;
   logic [DIV_W-1:0]   wden;
   assign wnum = ($signed(38'(raw_ff[widx_ff])) <<< 15) + 38'(sum_ff);
   assign wneg = wnum[37];
   assign wmag = wneg ? 37'(-wnum) : wnum[36:0];
   assign wden = {sum_ff[19:0], 1'b0};
   assign wsat = (wmag >= {wden, 16'b0});

   logic [16:0]        wq_up;
   logic signed [15:0] wgt_sat, wgt_div;
   assign wq_up   = 17'(div_quo[15:0]) + 17'(div_rem != '0);
   assign wgt_sat = wneg ? -16'sd32768 : 16'sd32767;
   always_comb begin
      if (!wneg) begin
         wgt_div = (div_quo[15:0] > 16'd32767) ? 16'sd32767 : $signed(div_quo[15:0]);
      end else begin
         wgt_div = (wq_up > 17'd32768) ? -16'sd32768 : 16'(-$signed(wq_up));
      end
   end

   logic [17:0] sq_up;
   assign sq_up = div_quo + 18'(div_rem != '0);

   logic [3:0] mask;
   always_comb begin
      mask = '0;
      for (int i = 0; i < NSLOT; i++) begin
         if (i < NUM_SERVERS) begin
            mask[i] = (load_ff <= high_ff) && (srv_ff[i][47:32] <= retain_ff);
         end
      end
   end

   // ---- dispatch helpers ----
   logic signed [49:0] cost;
   logic               feasible;
   assign cost = 50'(prod_ff) + 50'(r_ff);
   assign feasible = ({1'b0, used_ff[srv_idx_ff]} + {2'b0, cur_ff.request_load})
                     <= {2'b0, srv_ff[srv_idx_ff][15:0]};

   logic last_srv;
   assign last_srv = (srv_idx_ff == SRV_W'(NUM_SERVERS - 1));

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!in_empty && !out_full) begin
               state_in = (in_data.command == CMD_TICK) ? ST_T_SUM : ST_D_PREP1;
            end
         end
         ST_T_SUM:    state_in = ST_T_LOAD;
         ST_T_LOAD: begin
            if (cap_sum_ff == '0 || {1'b0, cap_sum_ff} <= used_sum_ff) begin
               state_in = ST_T_SLOPE;
            end else begin
               state_in = ST_T_LOADW;
            end
         end
         ST_T_LOADW:  if (div_done) state_in = ST_T_SLOPE;
         ST_T_SLOPE: begin
            if (prev_ff == '0 || slope_sat) begin
               state_in = ST_T_RAW;
            end else begin
               state_in = ST_T_SLOPEW;
            end
         end
         ST_T_SLOPEW: if (div_done) state_in = ST_T_RAW;
         ST_T_RAW:    state_in = ST_T_WGT;
         ST_T_WGT: begin
            if (!wsat) begin
               state_in = ST_T_WGTW;
            end else if (widx_ff == 2'd3) begin
               state_in = ST_T_FIN;
            end
         end
         ST_T_WGTW: begin
            if (div_done) begin
               state_in = (widx_ff == 2'd3) ? ST_T_FIN : ST_T_WGT;
            end
         end
         ST_T_FIN:    state_in = ST_IDLE;
         ST_D_PREP1:  state_in = ST_D_PREP2;
         ST_D_PREP2:  state_in = ST_D_MUL1;
         ST_D_MUL1:   state_in = ST_D_MUL2;
         ST_D_MUL2:   state_in = ST_D_ACC;
         ST_D_ACC:    state_in = last_srv ? ST_D_FIN : ST_D_MUL1;
         ST_D_FIN:    state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---- outputs ----
   always_comb begin
      in_pop   = 1'b0;
      out_push = 1'b0;
      div_cmd  = '0;
      out_data = '0;
      unique case (state_ff)
         ST_IDLE:  in_pop = !in_empty && !out_full;
         ST_T_LOAD: begin
            div_cmd.start = !(cap_sum_ff == '0 || {1'b0, cap_sum_ff} <= used_sum_ff);
            div_cmd.hi    = DIV_W'(used_sum_ff);
            div_cmd.steps = DIV_CNT_W'(16);
            div_cmd.den   = DIV_W'(cap_sum_ff);
         end
         ST_T_SLOPE: begin
            div_cmd.start = !(prev_ff == '0 || slope_sat);
            div_cmd.hi    = DIV_W'(diff_mag[15:4]);
            div_cmd.lo    = {diff_mag[3:0], 14'b0};
            div_cmd.steps = DIV_CNT_W'(18);
            div_cmd.den   = DIV_W'(prev_ff);
         end
         ST_T_WGT: begin
            div_cmd.start = !wsat;
            div_cmd.hi    = DIV_W'(wmag[36:16]);
            div_cmd.lo    = {wmag[15:0], 2'b0};
            div_cmd.steps = DIV_CNT_W'(16);
            div_cmd.den   = wden;
         end
         ST_T_FIN: begin
            out_push             = 1'b1;
            out_data.result_kind = KIND_TICK;
            out_data.slot_load   = load_ff;
            out_data.retain_mask = mask;
         end
         ST_D_FIN: begin
            out_push               = 1'b1;
            out_data.result_kind   = KIND_DISPATCH;
            out_data.echo_tag      = cur_ff.request_tag;
            out_data.placed        = best_ok_ff;
            out_data.chosen_server = best_ok_ff ? best_idx_ff : '0;
            out_data.best_cost     = best_ok_ff ? {{4{best_ff[49]}}, best_ff[49:14]} : '0;
         end
         default: begin
         end
      endcase
   end

   // ---- control and architectural state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         low_ff    <= LOW_THR_RST;
         high_ff   <= HIGH_THR_RST;
         retain_ff <= RETAIN_LIM_RST;
         prev_ff   <= '0;
         wgt_ff[0] <= 16'sd8192;
         wgt_ff[1] <= 16'sd3277;
         wgt_ff[2] <= 16'sd3277;
         wgt_ff[3] <= 16'sd1638;
         for (int i = 0; i < NSLOT; i++) begin
            srv_ff[i]  <= '0;
            used_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr.write_en) begin
            if (csr.index <= REG_SERVER3) begin
               srv_ff[csr.index[1:0]] <= csr.data;
            end else if (csr.index == REG_LOW_THR) begin
               low_ff <= csr.data[15:0];
            end else if (csr.index == REG_HIGH_THR) begin
               high_ff <= csr.data[15:0];
            end else if (csr.index == REG_RETAIN_LIM) begin
               retain_ff <= csr.data[15:0];
            end
         end
         if (state_ff == ST_T_WGT && wsat) begin
            wgt_ff[widx_ff] <= wgt_sat;
         end
         if (state_ff == ST_T_WGTW && div_done) begin
            wgt_ff[widx_ff] <= wgt_div;
         end
         if (state_ff == ST_T_FIN) begin
            prev_ff <= load_ff;
         end
         if (state_ff == ST_D_FIN && best_ok_ff) begin
            used_ff[best_idx_ff] <= 17'(used_ff[best_idx_ff] + 17'(cur_ff.request_load));
         end
      end
   end

   // ---- datapath ----
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: cur_ff <= in_data;
         ST_T_SUM: begin
            cap_sum_ff  <= cap_sum_in;
            used_sum_ff <= used_sum_in;
         end
         ST_T_LOAD: begin
            if (cap_sum_ff == '0) begin
               load_ff <= '0;
            end else if ({1'b0, cap_sum_ff} <= used_sum_ff) begin
               load_ff <= 16'hFFFF;
            end
         end
         ST_T_LOADW: if (div_done) load_ff <= div_quo[15:0];
         ST_T_SLOPE: begin
            neg_ff <= diff_neg;
            if (prev_ff == '0) begin
               slope_ff <= '0;
            end else if (slope_sat) begin
               slope_ff <= SLOPE_MAX;
            end
         end
         ST_T_SLOPEW: begin
            if (div_done) begin
               slope_ff <= neg_ff ? -$signed(19'(sq_up)) : $signed(19'(div_quo));
            end
         end
         ST_T_RAW: begin
            for (int i = 0; i < NSLOT; i++) begin
               raw_ff[i] <= raw_in[i];
            end
            sum_ff  <= sum_in;
            widx_ff <= '0;
         end
         ST_T_WGT:  if (wsat) widx_ff <= widx_ff + 1'b1;
         ST_T_WGTW: if (div_done) widx_ff <= widx_ff + 1'b1;
         ST_D_PREP1: begin
            a_ff       <= 32'(wgt_ff[2]) * $signed({16'b0, cur_ff.transfer_cost});
            srv_idx_ff <= '0;
            best_ok_ff <= 1'b0;
         end
         ST_D_PREP2: begin
            common_ff <= 34'(a_ff)
                         + 34'(32'(wgt_ff[3]) * $signed({16'b0, cur_ff.preparation_cost}));
         end
         ST_D_MUL1: begin
            p_ff <= srv_ff[srv_idx_ff][31:16] * cur_ff.request_load;
            r_ff <= 35'(32'(wgt_ff[1]) * $signed({16'b0, srv_ff[srv_idx_ff][47:32]}))
                    + 35'(common_ff);
         end
         ST_D_MUL2: prod_ff <= 49'(wgt_ff[0]) * $signed({17'b0, p_ff});
         ST_D_ACC: begin
            if (feasible && (!best_ok_ff || cost < best_ff)) begin
               best_ff     <= cost;
               best_idx_ff <= srv_idx_ff;
               best_ok_ff  <= 1'b1;
            end
            srv_idx_ff <= srv_idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end
endmodule

>>> hw/rtl/load_adaptive_weighted_dispatcher.sv
// Load-adaptive weighted dispatcher. Requests and slot ticks enter through a
// request queue (front), a sequencing engine (back) handles one transaction at
// a time and writes each result into a response queue. A dispatch walks the
// servers in turn through multiply and accumulate steps, after steps that
// prepare the common cost term. A tick runs three jobs on one shared
// restoring divider at one quotient bit per cycle: the load (16 quotient bits),
// the slope (18 quotient bits) and four weight normalizations (16 quotient bits
// each). Weights, previous load and used capacity are held in flops; weights
// change during a tick, the others only when a transaction completes. Configuration writes
// take effect at once and belong to idle time.
module load_adaptive_weighted_dispatcher
   import lawd_pkg::*;
#(
   parameter int NUM_SERVERS = 4,
   parameter int REQ_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   csr_type csr;
   req_type eng_in;
   rsp_type eng_out;
   logic    eng_in_empty, eng_pop, eng_out_full, eng_push;

   assign csr.write_en = csr_write_en;
   assign csr.index    = csr_index;
   assign csr.data     = csr_data;

   // front: transaction queue
   lawd_fifo #(.WIDTH($bits(req_type)), .DEPTH(REQ_DEPTH)) u_req_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_data),
      .full      (req_full),
      .pop       (eng_pop),
      .pop_data  (eng_in),
      .empty     (eng_in_empty)
   );

   // back: tick and dispatch sequencer
   lawd_engine #(.NUM_SERVERS(NUM_SERVERS)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .in_empty (eng_in_empty),
      .in_data  (eng_in),
      .in_pop   (eng_pop),
      .out_full (eng_out_full),
      .out_push (eng_push),
      .out_data (eng_out)
   );

   // results wait here so the engine can take the next transaction
   lawd_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .push_data (eng_out),
      .full      (eng_out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );
endmodule

>>> hw/rtl/lawd_checker.sv
module lawd_checker
   import lawd_pkg::*;
#(
   parameter int NUM_SERVERS = 4
) (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input rsp_type rsp_data
);
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_tick_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.result_kind == KIND_TICK) |->
         (rsp_data.echo_tag == '0 && !rsp_data.placed && rsp_data.best_cost == '0))
      else $error("tick result carries dispatch fields");

   a_dispatch_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.result_kind == KIND_DISPATCH) |->
         (rsp_data.slot_load == '0 && rsp_data.retain_mask == '0))
      else $error("dispatch result carries tick fields");

   a_unplaced: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.placed) |->
         (rsp_data.chosen_server == '0 && rsp_data.best_cost == '0))
      else $error("unplaced result has a server or cost");

   a_server_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ({30'b0, rsp_data.chosen_server} < NUM_SERVERS &&
                      (rsp_data.retain_mask >> NUM_SERVERS) == '0))
      else $error("server outside configured range");
endmodule

bind load_adaptive_weighted_dispatcher lawd_checker #(.NUM_SERVERS(NUM_SERVERS)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_data  (rsp_data)
);

>>> tb/testbench.sv
module testbench;
   import lawd_pkg::*;

   // register indexes not named in the package
   localparam logic [CSR_IDX_W-1:0] REG_SERVER0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SERVER1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SERVER2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   load_adaptive_weighted_dispatcher uut (.*);

   // shadow of block configuration and state
   logic [47:0] srv_cfg [NSLOT];
   logic [15:0] low_thr, high_thr, retain_lim;
   logic [16:0] used_cap [NSLOT];
   logic [15:0] prev_load;
   logic signed [15:0] weights [NSLOT];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int cycles = 0;
   bit failed = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint fdiv(longint n, longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   // computes the result of one transaction and advances the shadow state
   function automatic rsp_type dispatch_predict(req_type r);
      rsp_type o;
      longint cap_sum, used_sum, load, slope, sum, w, best, cost, q, lim;
      longint raw [4];
      longint base_v, k_v;
      int band, best_idx;
      o = '0;
      lim = (longint'(1) << 39) - 1;
      if (r.command == CMD_TICK) begin
         cap_sum = 0;
         used_sum = 0;
         for (int i = 0; i < NSLOT; i++) begin
            cap_sum += srv_cfg[i][15:0];
            used_sum += used_cap[i];
         end
         if (cap_sum == 0) load = 0;
         else begin
            load = (used_sum << 16) / cap_sum;
            if (load > 65535) load = 65535;
         end
         slope = 0;
         if (prev_load != 0) begin
            slope = fdiv((load - longint'(prev_load)) * 16384, longint'(prev_load));
            if (slope > 245760) slope = 245760;
            if (slope < -16384) slope = -16384;
         end
         if (load <= low_thr) band = 0;
         else if (load <= high_thr) band = 1;
         else band = 2;
         sum = 0;
         for (int i = 0; i < 4; i++) begin
            case (i)
               0: base_v = (band == 0) ? 10 : (band == 1) ? 8 : 6;
               1: base_v = (band == 0) ? 4 : (band == 1) ? 6 : 8;
               2: base_v = 4;
               default: base_v = 2;
            endcase
            if (band == 0) k_v = 0;
            else if (i == 0) k_v = 2;
            else if (i == 1) k_v = (band == 1) ? 1 : 2;
            else k_v = -1;
            raw[i] = base_v * 16384 + k_v * slope;
            sum += raw[i];
         end
         for (int i = 0; i < 4; i++) begin
            w = fdiv(2 * raw[i] * 16384 + sum, 2 * sum);
            if (w > 32767) w = 32767;
            if (w < -32768) w = -32768;
            weights[i] = w[15:0];
         end
         for (int i = 0; i < NSLOT; i++)
            if (load <= high_thr && srv_cfg[i][47:32] <= retain_lim)
               o.retain_mask[i] = 1'b1;
         prev_load = load[15:0];
         o.result_kind = KIND_TICK;
         o.slot_load = load[15:0];
      end else begin
         best_idx = -1;
         best = 0;
         for (int i = 0; i < NSLOT; i++) begin
            if (longint'(used_cap[i]) + r.request_load > srv_cfg[i][15:0]) continue;
            cost = longint'(weights[0]) * (longint'(srv_cfg[i][31:16]) * r.request_load)
                 + longint'(weights[1]) * longint'(srv_cfg[i][47:32])
                 + longint'(weights[2]) * longint'(r.transfer_cost)
                 + longint'(weights[3]) * longint'(r.preparation_cost);
            if (best_idx < 0 || cost < best) begin
               best = cost;
               best_idx = i;
            end
         end
         o.result_kind = KIND_DISPATCH;
         o.echo_tag = r.request_tag;
         if (best_idx >= 0) begin
            used_cap[best_idx] = used_cap[best_idx] + r.request_load;
            q = fdiv(best, 16384);
            if (q > lim) q = lim;
            if (q < -lim - 1) q = -lim - 1;
            o.placed = 1'b1;
            o.chosen_server = best_idx[1:0];
            o.best_cost = q[39:0];
         end
      end
      return o;
   endfunction

   // driver: push holds while full; a new transaction goes up only after acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            expected_rsps.push_back(dispatch_predict(req_data));
            void'(pending_reqs.pop_front());
         end
         if (req_push && req_full) begin
            // hold current transaction
         end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_push <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // monitor: checks each popped transaction against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected transaction %p", $realtime, rsp_data);
               failed = 1'b1;
            end else begin
               e = expected_rsps.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t: mismatch expected %p actual %p", $realtime, e, rsp_data);
                  failed = 1'b1;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("load_adaptive_weighted_dispatcher verification failed");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [47:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx <= REG_SERVER3) srv_cfg[idx] = val;
      else if (idx == REG_LOW_THR) low_thr = val[15:0];
      else if (idx == REG_HIGH_THR) high_thr = val[15:0];
      else if (idx == REG_RETAIN_LIM) retain_lim = val[15:0];
   endtask

   // waits until the queues drain and every expected result is checked, then idles
   task automatic drain();
      while (pending_reqs.size() > 0 || req_push || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic req_type make_req(logic cmd, logic [15:0] ld, logic [15:0] tr,
                                        logic [15:0] pr);
      req_type r;
      r.command = cmd;
      r.request_tag = 16'($urandom);
      r.request_load = ld;
      r.transfer_cost = tr;
      r.preparation_cost = pr;
      return r;
   endfunction

   function automatic logic [47:0] rand_server(int cap_max);
      return {16'($urandom), 16'($urandom), 16'($urandom_range(cap_max))};
   endfunction

   task automatic random_phase(int n, int cap_max);
      for (int s = 0; s < NSLOT; s++) write_reg(s[2:0], rand_server(cap_max));
      write_reg(REG_LOW_THR, 48'(16'($urandom)));
      write_reg(REG_HIGH_THR, 48'(16'($urandom)));
      write_reg(REG_RETAIN_LIM, 48'(16'($urandom)));
      for (int i = 0; i < n; i++) begin
         // mostly dispatches with loads sized to fill capacity, some ticks
         if ($urandom_range(7) == 0)
            pending_reqs.push_back(make_req(CMD_TICK, 16'($urandom), 16'($urandom),
                                            16'($urandom)));
         else if ($urandom_range(9) == 0)
            pending_reqs.push_back(make_req(CMD_DISPATCH, 16'($urandom), 16'($urandom),
                                            16'($urandom)));
         else
            pending_reqs.push_back(make_req(CMD_DISPATCH,
                                            16'($urandom_range(cap_max / 8 + 1)),
                                            16'($urandom), 16'($urandom)));
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         srv_cfg[i] = '0;
         used_cap[i] = '0;
      end
      low_thr = LOW_THR_RST;
      high_thr = HIGH_THR_RST;
      retain_lim = RETAIN_LIM_RST;
      prev_load = '0;
      weights[0] = 16'sd8192;
      weights[1] = 16'sd3277;
      weights[2] = 16'sd3277;
      weights[3] = 16'sd1638;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero total capacity: tick gives zero load, only a zero-load dispatch is placeable
      pending_reqs.push_back(make_req(CMD_TICK, 16'h0, 16'h0, 16'h0));
      pending_reqs.push_back(make_req(CMD_DISPATCH, 16'h1, 16'hffff, 16'hffff));
      pending_reqs.push_back(make_req(CMD_DISPATCH, 16'h0, 16'h0, 16'h0));
      drain();

      // directed: equal servers for ties, extremes of costs and loads
      write_reg(REG_UNUSED, 48'hffff_ffff_ffff);
      write_reg(REG_SERVER0, {16'hffff, 16'hffff, 16'h0100});
      write_reg(REG_SERVER1, {16'h0000, 16'h0000, 16'hffff});
      write_reg(REG_SERVER2, {16'h0000, 16'h0000, 16'hffff});
      write_reg(REG_SERVER3, {16'h8000, 16'h8001, 16'h0010});
      pending_reqs.push_back(make_req(CMD_DISPATCH, 16'h0010, 16'hffff, 16'hffff));
      pending_reqs.push_back(make_req(CMD_DISPATCH, 16'hffff, 16'h0, 16'h0));
      pending_reqs.push_back(make_req(CMD_DISPATCH, 16'hffff, 16'h0, 16'h0));
      pending_reqs.push_back(make_req(CMD_TICK, 16'h0, 16'h0, 16'h0));
      pending_reqs.push_back(make_req(CMD_DISPATCH, 16'h00f0, 16'h1234, 16'h8000));
      pending_reqs.push_back(make_req(CMD_TICK, 16'h0, 16'h0, 16'h0));
      pending_reqs.push_back(make_req(CMD_DISPATCH, 16'h0100, 16'hffff, 16'h0));
      pending_reqs.push_back(make_req(CMD_TICK, 16'h0, 16'h0, 16'h0));
      drain();
      // shrink capacity below usage: load saturates, steep slope
      write_reg(REG_SERVER1, {16'hffff, 16'hffff, 16'h0001});
      write_reg(REG_SERVER2, 48'h0);
      write_reg(REG_LOW_THR, 48'h0000);
      write_reg(REG_HIGH_THR, 48'hffff);
      write_reg(REG_RETAIN_LIM, 48'hffff);
      pending_reqs.push_back(make_req(CMD_TICK, 16'h0, 16'h0, 16'h0));
      pending_reqs.push_back(make_req(CMD_TICK, 16'h0, 16'h0, 16'h0));
      pending_reqs.push_back(make_req(CMD_DISPATCH, 16'h0, 16'hffff, 16'hffff));
      drain();

      // random phases across idle and stall mixes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; pop_stall_pct = 0; end
            1: begin send_idle_pct = 47; pop_stall_pct = 0; end
            2: begin send_idle_pct = 0; pop_stall_pct = 47; end
            default: begin send_idle_pct = 15; pop_stall_pct = 15; end
         endcase
         random_phase(85, (ph < 4) ? 2000 : 65535);
      end

      if (!failed && expected_rsps.size() == 0) begin
         $display("load_adaptive_weighted_dispatcher verification clean");
      end else begin
         $display("load_adaptive_weighted_dispatcher verification failed");
      end
      $finish;
   end

endmodule
